[hdl/dbl_pkg.sv]
package dbl_pkg;

  localparam int MAX_PACK   = 32;
  localparam int HDR_BYTES  = 24;
  localparam int WIDTH_MAX  = 64;
  localparam int VAL_W      = 64;
  localparam int CNT_W      = $clog2(MAX_PACK + 1);
  localparam int HIDX_W     = $clog2(HDR_BYTES);
  localparam int ABITS_W    = $clog2(WIDTH_MAX + 1);

  // header byte boundaries
  localparam int HDR_CNT_END = 4;
  localparam int HDR_WID_END = 8;
  localparam int HDR_MIN_END = 16;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_COUNT_ERR = 2'd1,
    STATUS_WIDTH_ERR = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_HDR_END = 5'b00010,
    S_BIT     = 5'b00100,
    S_ADD     = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

endpackage

[hdl/delta_bitpack_long_decoder_unit.sv]
// Channel | Direction | Ports                                        | Handshake
// input   | in        | in_stream_byte[7:0]                          | in_valid / in_ready
// result  | out       | out_value[63:0] signed, out_is_first,        | out_valid / out_ready
//         |           | out_pack_done, out_status[1:0], out_last     |
//
// Steps: each header byte is accepted in the idle state; after the closing header
//   byte, S_HDR_END emits the first value, and a zero-width pack then runs S_ADD and
//   S_EMIT for each value. A delta byte is accepted, then S_BIT shifts in one bit at a
//   time; each completed delta passes S_ADD, where the single shared 64-bit adder runs
//   twice (prev + min_delta, then + delta), and S_EMIT, which loads the result into the
//   output register. The byte that closes a pack stops at its last delta and skips the padding bits.
// Reset: rst_n synchronous, active low; block starts waiting for a header.
// Stalls: one output register; while it is full and out_ready is low, any state
//   that must emit holds. in_ready is high only in the idle state.
module delta_bitpack_long_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_stream_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dbl_pkg::VAL_W-1:0]  out_value,
  output logic                              out_is_first,
  output logic                              out_pack_done,
  output logic [1:0]                        out_status,
  output logic                              out_last
);

  dbl_pkg::state_t state_r, state_nxt;
  logic                           phase_r, phase_nxt;      // 1: delta bytes
  logic [dbl_pkg::HIDX_W-1:0]     hdr_idx_r, hdr_idx_nxt;
  logic [31:0]                    count_r, count_nxt;
  logic [31:0]                    width_r, width_nxt;
  logic [dbl_pkg::VAL_W-1:0]      min_delta_r, min_delta_nxt;
  logic [dbl_pkg::VAL_W-1:0]      prev_r, prev_nxt;
  logic [dbl_pkg::VAL_W-1:0]      acc_r, acc_nxt;
  logic [dbl_pkg::ABITS_W-1:0]    abits_r, abits_nxt;
  logic [dbl_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;          // values still to emit
  logic                           zw_r, zw_nxt;            // zero-width fill mode
  logic                           step_r, step_nxt;        // adder pass
  logic [7:0]                     byte_r, byte_nxt;
  logic [2:0]                     bit_idx_r, bit_idx_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [dbl_pkg::VAL_W-1:0]      out_value_r, out_value_nxt;
  logic                           out_first_r, out_first_nxt;
  logic                           out_done_r, out_done_nxt;
  dbl_pkg::status_t               out_status_r, out_status_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           slot_free;
  logic                           in_acc;
  logic                           load;
  logic [dbl_pkg::VAL_W-1:0]      add_b;
  logic [dbl_pkg::VAL_W-1:0]      sum;
  logic [dbl_pkg::ABITS_W-1:0]    width_s;
  logic [dbl_pkg::ABITS_W-1:0]    abits_inc;
  logic                           cur_bit;
  logic                           last_cnt;

  assign in_ready  = (state_r == dbl_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // shared adder: first pass adds min_delta, second adds the unpacked delta
  assign add_b = step_r ? acc_r : min_delta_r;
  assign sum   = prev_r + add_b;

  // width is at most 64 whenever this narrow view is used
  assign width_s   = width_r[dbl_pkg::ABITS_W-1:0];
  assign abits_inc = abits_r + 1'b1;
  assign cur_bit   = byte_r[bit_idx_r];
  assign last_cnt  = (cnt_r == dbl_pkg::CNT_W'(1));

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    count_nxt      = count_r;
    width_nxt      = width_r;
    min_delta_nxt  = min_delta_r;
    prev_nxt       = prev_r;
    acc_nxt        = acc_r;
    abits_nxt      = abits_r;
    cnt_nxt        = cnt_r;
    zw_nxt         = zw_r;
    step_nxt       = step_r;
    byte_nxt       = byte_r;
    bit_idx_nxt    = bit_idx_r;
    load           = 1'b0;
    out_value_nxt  = out_value_r;
    out_first_nxt  = out_first_r;
    out_done_nxt   = out_done_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      dbl_pkg::S_IDLE: begin
        if (in_acc) begin
          if (!phase_r) begin
            // big-endian header fields
            if (hdr_idx_r < dbl_pkg::HIDX_W'(dbl_pkg::HDR_CNT_END)) begin
              count_nxt = {count_r[23:0], in_stream_byte};
            end else if (hdr_idx_r < dbl_pkg::HIDX_W'(dbl_pkg::HDR_WID_END)) begin
              width_nxt = {width_r[23:0], in_stream_byte};
            end else if (hdr_idx_r < dbl_pkg::HIDX_W'(dbl_pkg::HDR_MIN_END)) begin
              min_delta_nxt = {min_delta_r[dbl_pkg::VAL_W-9:0], in_stream_byte};
            end else begin
              prev_nxt = {prev_r[dbl_pkg::VAL_W-9:0], in_stream_byte};
            end
            if (hdr_idx_r == dbl_pkg::HIDX_W'(dbl_pkg::HDR_BYTES - 1)) begin
              hdr_idx_nxt = '0;
              state_nxt   = dbl_pkg::S_HDR_END;
            end else begin
              hdr_idx_nxt = hdr_idx_r + 1'b1;
            end
          end else begin
            byte_nxt    = in_stream_byte;
            bit_idx_nxt = 3'd7;
            state_nxt   = dbl_pkg::S_BIT;
          end
        end
      end

      dbl_pkg::S_HDR_END: begin
        if (slot_free) begin
          load          = 1'b1;
          out_value_nxt = prev_r;
          out_first_nxt = 1'b1;
          out_done_nxt  = 1'b0;
          out_status_nxt = dbl_pkg::STATUS_OK;
          out_last_nxt  = 1'b1;
          state_nxt     = dbl_pkg::S_IDLE;
          if (count_r > 32'(dbl_pkg::MAX_PACK)) begin
            out_value_nxt  = '0;
            out_first_nxt  = 1'b0;
            out_done_nxt   = 1'b1;
            out_status_nxt = dbl_pkg::STATUS_COUNT_ERR;
          end else if (width_r > 32'(dbl_pkg::WIDTH_MAX)) begin
            out_value_nxt  = '0;
            out_first_nxt  = 1'b0;
            out_done_nxt   = 1'b1;
            out_status_nxt = dbl_pkg::STATUS_WIDTH_ERR;
          end else if (count_r == '0) begin
            out_done_nxt = 1'b1;
          end else if (width_r == '0) begin
            // all values follow from min_delta alone
            out_last_nxt = 1'b0;
            cnt_nxt      = count_r[dbl_pkg::CNT_W-1:0];
            zw_nxt       = 1'b1;
            step_nxt     = 1'b0;
            state_nxt    = dbl_pkg::S_ADD;
          end else begin
            cnt_nxt   = count_r[dbl_pkg::CNT_W-1:0];
            zw_nxt    = 1'b0;
            phase_nxt = 1'b1;
            acc_nxt   = '0;
            abits_nxt = '0;
          end
        end
      end

      dbl_pkg::S_BIT: begin
        acc_nxt   = {acc_r[dbl_pkg::VAL_W-2:0], cur_bit};
        abits_nxt = abits_inc;
        if (abits_inc >= width_s) begin
          step_nxt  = 1'b0;
          state_nxt = dbl_pkg::S_ADD;
        end else if (bit_idx_r == 3'd0) begin
          state_nxt = dbl_pkg::S_IDLE;
        end else begin
          bit_idx_nxt = bit_idx_r - 1'b1;
        end
      end

      dbl_pkg::S_ADD: begin
        prev_nxt = sum;
        if (zw_r || step_r) begin
          step_nxt  = 1'b0;
          state_nxt = dbl_pkg::S_EMIT;
          if (!zw_r) begin
            acc_nxt   = '0;
            abits_nxt = '0;
          end
        end else begin
          step_nxt = 1'b1;
        end
      end

      dbl_pkg::S_EMIT: begin
        if (slot_free) begin
          load           = 1'b1;
          out_value_nxt  = prev_r;
          out_first_nxt  = 1'b0;
          out_done_nxt   = last_cnt;
          out_status_nxt = dbl_pkg::STATUS_OK;
          cnt_nxt        = cnt_r - 1'b1;
          if (zw_r) begin
            out_last_nxt = last_cnt;
            state_nxt    = last_cnt ? dbl_pkg::S_IDLE : dbl_pkg::S_ADD;
            zw_nxt       = !last_cnt;
          end else begin
            // last of this byte when no further delta fits in the bits left
            out_last_nxt = last_cnt || (width_s > dbl_pkg::ABITS_W'(bit_idx_r));
            if (last_cnt) begin
              phase_nxt = 1'b0;
              state_nxt = dbl_pkg::S_IDLE;
            end else if (bit_idx_r == 3'd0) begin
              state_nxt = dbl_pkg::S_IDLE;
            end else begin
              bit_idx_nxt = bit_idx_r - 1'b1;
              state_nxt   = dbl_pkg::S_BIT;
            end
          end
        end
      end

      default: begin
        state_nxt = dbl_pkg::S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbl_pkg::S_IDLE;
      phase_r     <= 1'b0;
      hdr_idx_r   <= '0;
      count_r     <= '0;
      width_r     <= '0;
      min_delta_r <= '0;
      prev_r      <= '0;
      acc_r       <= '0;
      abits_r     <= '0;
      cnt_r       <= '0;
      zw_r        <= 1'b0;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      count_r     <= count_nxt;
      width_r     <= width_nxt;
      min_delta_r <= min_delta_nxt;
      prev_r      <= prev_nxt;
      acc_r       <= acc_nxt;
      abits_r     <= abits_nxt;
      cnt_r       <= cnt_nxt;
      zw_r        <= zw_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    bit_idx_r    <= bit_idx_nxt;
    out_value_r  <= out_value_nxt;
    out_first_r  <= out_first_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = $signed(out_value_r);
  assign out_is_first  = out_first_r;
  assign out_pack_done = out_done_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status_r != dbl_pkg::STATUS_OK)
      |-> out_done_r && out_last_r && !out_first_r && (out_value_r == '0))
    else $error("error result with bad flags");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_r |-> out_last_r)
    else $error("pack end not last of its byte");

  a_delta_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (cnt_r != '0))
    else $error("delta phase with no values left");

  a_no_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("output register overwritten");
`endif

endmodule
